@@ rtl/core/mbp_pkg.sv @@
`default_nettype none

package mbp_pkg;

   // Latency from an accepted request to its response strobe, in cycles
   localparam int RESULT_LATENCY = 10;

   // Full-scale byte value
   localparam logic [7:0] FULL_SCALE = 8'd255;

   // Register indexes, decoded from paddr[2]
   localparam logic REG_SOURCE_OPACITY = 1'b0;
   localparam logic REG_TARGET_OPACITY = 1'b1;

   // Number of color channels (red, green, blue)
   localparam int NUM_CHANNELS = 3;

   typedef struct packed {
      logic [7:0] src_red;
      logic [7:0] src_green;
      logic [7:0] src_blue;
      logic [7:0] src_alpha;
      logic [7:0] dst_red;
      logic [7:0] dst_green;
      logic [7:0] dst_blue;
      logic [7:0] dst_alpha;
   } mbp_req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
   } mbp_rsp_type;

   // Premultiplied channels and scaled alphas, index 0 is red
   typedef struct packed {
      logic [NUM_CHANNELS-1:0][7:0] sp;
      logic [NUM_CHANNELS-1:0][7:0] dp;
      logic [7:0]                   sa;
      logic [7:0]                   da;
   } mbp_premul_type;

   // Blended premultiplied channels and result alpha
   typedef struct packed {
      logic [NUM_CHANNELS-1:0][7:0] c;
      logic [7:0]                   ra;
   } mbp_mix_type;

   // Byte product round(a*b/255); x/255 for x below 65535 is (x + 1 + (x >> 8)) >> 8
   function automatic logic [7:0] bmul(input logic [7:0] a, input logic [7:0] b);
      logic [15:0] x;
      logic [16:0] y;
      x = {8'b0, a} * {8'b0, b} + 16'd127;
      y = {1'b0, x} + 17'd1 + {9'b0, x[15:8]};
      return y[15:8];
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/mbp_premul.sv @@
`default_nettype none

module mbp_premul (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_valid,
   input  mbp_pkg::mbp_req_type in_data,
   input  wire [7:0]            source_opacity,
   input  wire [7:0]            target_opacity,
   output logic                 out_valid,
   output mbp_pkg::mbp_premul_type out_data
);
   import mbp_pkg::*;

   logic        a_valid_ff;
   mbp_req_type a_pix_ff;
   logic [7:0]  a_sa_in;
   logic [7:0]  a_da_in;
   logic [7:0]  a_sa_ff;
   logic [7:0]  a_da_ff;

   logic           b_valid_ff;
   mbp_premul_type b_data_in;
   mbp_premul_type b_data_ff;

   // Scale both alphas by their layer opacity
   assign a_sa_in = bmul(in_data.src_alpha, source_opacity);
   assign a_da_in = bmul(in_data.dst_alpha, target_opacity);

   // Premultiply each color channel by its scaled alpha
   always_comb begin
      b_data_in.sp[0] = bmul(a_pix_ff.src_red,   a_sa_ff);
      b_data_in.sp[1] = bmul(a_pix_ff.src_green, a_sa_ff);
      b_data_in.sp[2] = bmul(a_pix_ff.src_blue,  a_sa_ff);
      b_data_in.dp[0] = bmul(a_pix_ff.dst_red,   a_da_ff);
      b_data_in.dp[1] = bmul(a_pix_ff.dst_green, a_da_ff);
      b_data_in.dp[2] = bmul(a_pix_ff.dst_blue,  a_da_ff);
      b_data_in.sa    = a_sa_ff;
      b_data_in.da    = a_da_ff;
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      a_pix_ff  <= in_data;
      a_sa_ff   <= a_sa_in;
      a_da_ff   <= a_da_in;
      b_data_ff <= b_data_in;
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/mbp_mix.sv @@
`default_nettype none

module mbp_mix (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     in_valid,
   input  mbp_pkg::mbp_premul_type in_data,
   output logic                    out_valid,
   output mbp_pkg::mbp_mix_type    out_data
);
   import mbp_pkg::*;

   logic                         c_valid_ff;
   logic [NUM_CHANNELS-1:0][7:0] c_p0_in;
   logic [NUM_CHANNELS-1:0][7:0] c_p1_in;
   logic [NUM_CHANNELS-1:0][7:0] c_p2_in;
   logic [NUM_CHANNELS-1:0][7:0] c_p0_ff;
   logic [NUM_CHANNELS-1:0][7:0] c_p1_ff;
   logic [NUM_CHANNELS-1:0][7:0] c_p2_ff;
   logic [7:0]                   c_sa_ff;
   logic [7:0]                   c_da_ff;
   logic [7:0]                   c_sada_in;
   logic [7:0]                   c_sada_ff;

   logic        d_valid_ff;
   mbp_mix_type d_data_in;
   mbp_mix_type d_data_ff;
   logic [8:0]  d_alpha_sum;

   // Form the three product terms per channel and the alpha overlap
   always_comb begin
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         c_p0_in[ch] = bmul(in_data.sp[ch], in_data.dp[ch]);
         c_p1_in[ch] = bmul(in_data.sp[ch], FULL_SCALE - in_data.da);
         c_p2_in[ch] = bmul(in_data.dp[ch], FULL_SCALE - in_data.sa);
      end
      c_sada_in = bmul(in_data.sa, in_data.da);
   end

   // Sum the terms with saturation; union of alphas
   always_comb begin
      logic [9:0] sum;
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         sum = {2'b0, c_p0_ff[ch]} + {2'b0, c_p1_ff[ch]} + {2'b0, c_p2_ff[ch]};
         d_data_in.c[ch] = (sum > {2'b0, FULL_SCALE}) ? FULL_SCALE : sum[7:0];
      end
      d_alpha_sum  = {1'b0, c_sa_ff} + {1'b0, c_da_ff} - {1'b0, c_sada_ff};
      d_data_in.ra = (d_alpha_sum > {1'b0, FULL_SCALE}) ? FULL_SCALE : d_alpha_sum[7:0];
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= in_valid;
         d_valid_ff <= c_valid_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      c_p0_ff   <= c_p0_in;
      c_p1_ff   <= c_p1_in;
      c_p2_ff   <= c_p2_in;
      c_sa_ff   <= in_data.sa;
      c_da_ff   <= in_data.da;
      c_sada_ff <= c_sada_in;
      d_data_ff <= d_data_in;
   end

   assign out_valid = d_valid_ff;
   assign out_data  = d_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/mbp_unpremul.sv @@
`default_nettype none

module mbp_unpremul (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_valid,
   input  mbp_pkg::mbp_mix_type in_data,
   output logic                 out_valid,
   output mbp_pkg::mbp_rsp_type out_data
);
   import mbp_pkg::*;

   localparam int DivBits     = 8;
   localparam int StepsPerStg = 2;
   localparam int DivStages   = DivBits / StepsPerStg;

   // Setup stage: numerator c*255 + ra/2, split into starting remainder and low bits
   logic                         e_valid_ff;
   logic [7:0]                   e_div_ff;
   logic                         e_zero_ff;
   logic [NUM_CHANNELS-1:0]      e_sat_in;
   logic [NUM_CHANNELS-1:0]      e_sat_ff;
   logic [NUM_CHANNELS-1:0][7:0] e_rem_in;
   logic [NUM_CHANNELS-1:0][7:0] e_low_in;
   logic [NUM_CHANNELS-1:0][7:0] e_rem_ff;
   logic [NUM_CHANNELS-1:0][7:0] e_low_ff;

   // Divider stages, two quotient bits each
   logic [DivStages-1:0]                         dv_ff;
   logic [DivStages-1:0][7:0]                    dd_ff;
   logic [DivStages-1:0]                         dz_ff;
   logic [DivStages-1:0][NUM_CHANNELS-1:0]       ds_ff;
   logic [DivStages-1:0][NUM_CHANNELS-1:0][7:0]  dr_in;
   logic [DivStages-1:0][NUM_CHANNELS-1:0][7:0]  dl_in;
   logic [DivStages-1:0][NUM_CHANNELS-1:0][7:0]  dq_in;
   logic [DivStages-1:0][NUM_CHANNELS-1:0][7:0]  dr_ff;
   logic [DivStages-1:0][NUM_CHANNELS-1:0][7:0]  dl_ff;
   logic [DivStages-1:0][NUM_CHANNELS-1:0][7:0]  dq_ff;

   logic                         rsp_valid_ff;
   logic [NUM_CHANNELS-1:0][7:0] rsp_col_in;
   mbp_rsp_type                  rsp_data_in;
   mbp_rsp_type                  rsp_data_ff;

   // Restoring division steps: returns {remainder, low bits, quotient}
   function automatic logic [23:0] div_steps(input logic [7:0] rem, input logic [7:0] low,
                                             input logic [7:0] quo, input logic [7:0] div);
      logic [8:0] t;
      logic [7:0] r;
      logic [7:0] l;
      logic [7:0] q;
      r = rem;
      l = low;
      q = quo;
      for (int k = 0; k < StepsPerStg; k++) begin
         t = {r, l[7]};
         l = {l[6:0], 1'b0};
         if (t >= {1'b0, div}) begin
            r = 8'(t - {1'b0, div});
            q = {q[6:0], 1'b1};
         end else begin
            r = t[7:0];
            q = {q[6:0], 1'b0};
         end
      end
      return {r, l, q};
   endfunction

   // Build numerator; a channel at or above a nonzero alpha clamps to full scale
   always_comb begin
      logic [15:0] num;
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         num = {in_data.c[ch], 8'b0} - {8'b0, in_data.c[ch]} + {9'b0, in_data.ra[7:1]};
         e_rem_in[ch] = num[15:8];
         e_low_in[ch] = num[7:0];
         e_sat_in[ch] = (in_data.c[ch] >= in_data.ra);
      end
   end

   // Run the divider stages
   always_comb begin
      for (int s = 0; s < DivStages; s++) begin
         for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            if (s == 0) begin
               {dr_in[s][ch], dl_in[s][ch], dq_in[s][ch]} =
                  div_steps(e_rem_ff[ch], e_low_ff[ch], 8'b0, e_div_ff);
            end else begin
               {dr_in[s][ch], dl_in[s][ch], dq_in[s][ch]} =
                  div_steps(dr_ff[s-1][ch], dl_ff[s-1][ch], dq_ff[s-1][ch], dd_ff[s-1]);
            end
         end
      end
   end

   // Select zero, clamp or quotient
   always_comb begin
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         if (dz_ff[DivStages-1]) begin
            rsp_col_in[ch] = 8'b0;
         end else if (ds_ff[DivStages-1][ch]) begin
            rsp_col_in[ch] = FULL_SCALE;
         end else begin
            rsp_col_in[ch] = dq_ff[DivStages-1][ch];
         end
      end
      rsp_data_in.out_red   = rsp_col_in[0];
      rsp_data_in.out_green = rsp_col_in[1];
      rsp_data_in.out_blue  = rsp_col_in[2];
      rsp_data_in.out_alpha = dd_ff[DivStages-1];
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff   <= 1'b0;
         dv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         e_valid_ff   <= in_valid;
         dv_ff        <= {dv_ff[DivStages-2:0], e_valid_ff};
         rsp_valid_ff <= dv_ff[DivStages-1];
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      e_div_ff  <= in_data.ra;
      e_zero_ff <= (in_data.ra == 8'b0);
      e_sat_ff  <= e_sat_in;
      e_rem_ff  <= e_rem_in;
      e_low_ff  <= e_low_in;
      for (int s = 0; s < DivStages; s++) begin
         if (s == 0) begin
            dd_ff[s] <= e_div_ff;
            dz_ff[s] <= e_zero_ff;
            ds_ff[s] <= e_sat_ff;
         end else begin
            dd_ff[s] <= dd_ff[s-1];
            dz_ff[s] <= dz_ff[s-1];
            ds_ff[s] <= ds_ff[s-1];
         end
      end
      dr_ff       <= dr_in;
      dl_ff       <= dl_in;
      dq_ff       <= dq_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/multiply_blend_pixel_unit.sv @@
`default_nettype none

// Multiply blend of two RGBA8 pixels (straight alpha in and out).
// Request: drive req_data with a source and a destination pixel and pulse
// start; the word is taken at any edge where start is high and busy is low.
// busy stays low, so a new pixel can be taken every cycle.
// Response: rsp_valid is high for exactly one cycle with the blended pixel on
// rsp_data; one response per request, in order. The receiver cannot stall:
// it must take each word as it appears. Throughput is one pixel per clock;
// each pixel passes through the ten-stage pipe (alpha scaling, premultiply,
// product terms, saturating sum, numerator setup, four two-bit stages of the
// un-premultiply divider, output register).
// Configuration: APB-style port, source_opacity at 0x0, target_opacity at 0x4,
// 8 bits each in pwdata[7:0]; change them only while no pixel is in flight.
// Reset (synchronous, active high) drops every pixel in flight and sets both
// opacities to 255.
module multiply_blend_pixel_unit (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   input  mbp_pkg::mbp_req_type req_data,
   output logic                 rsp_valid,
   output mbp_pkg::mbp_rsp_type rsp_data,
   input  wire                  psel,
   input  wire                  penable,
   input  wire                  pwrite,
   input  wire [2:0]            paddr,
   input  wire [31:0]           pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   import mbp_pkg::*;

   logic [7:0]     source_opacity_ff;
   logic [7:0]     target_opacity_ff;
   logic           csr_write;

   logic           pre_valid;
   mbp_premul_type pre_data;
   logic           mix_valid;
   mbp_mix_type    mix_data;

   // Register write and read-back
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_opacity_ff <= FULL_SCALE;
         target_opacity_ff <= FULL_SCALE;
      end else if (csr_write) begin
         if (paddr[2] == REG_SOURCE_OPACITY) begin
            source_opacity_ff <= pwdata[7:0];
         end else begin
            target_opacity_ff <= pwdata[7:0];
         end
      end
   end

   always_comb begin
      if (paddr[2] == REG_TARGET_OPACITY) begin
         prdata = {24'b0, target_opacity_ff};
      end else begin
         prdata = {24'b0, source_opacity_ff};
      end
   end

   // Fully pipelined: never hold off a request
   assign busy = 1'b0;

   mbp_premul u_premul (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (start && !busy),
      .in_data        (req_data),
      .source_opacity (source_opacity_ff),
      .target_opacity (target_opacity_ff),
      .out_valid      (pre_valid),
      .out_data       (pre_data)
   );

   mbp_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pre_valid),
      .in_data   (pre_data),
      .out_valid (mix_valid),
      .out_data  (mix_data)
   );

   mbp_unpremul u_unpremul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mix_valid),
      .in_data   (mix_data),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ rtl/core/mbp_checker.sv @@
`default_nettype none

module mbp_checker (
   input wire                  clock,
   input wire                  reset,
   input wire                  start,
   input wire                  busy,
   input wire                  rsp_valid,
   input mbp_pkg::mbp_rsp_type rsp_data,
   input wire                  psel,
   input wire                  penable,
   input wire                  pwrite,
   input wire [2:0]            paddr,
   input wire [31:0]           pwdata,
   input wire [31:0]           prdata,
   input wire                  pready
);
   import mbp_pkg::*;

   // The pipe never pushes back
   assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   // Every response word traces back to a request a fixed latency earlier
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, RESULT_LATENCY))
      else $error("response without matching request");

   // Transparent result carries no color
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.out_alpha == 8'd0) |->
         (rsp_data.out_red == 8'd0 && rsp_data.out_green == 8'd0 &&
          rsp_data.out_blue == 8'd0))
      else $error("color on zero alpha");

   // A source opacity write reads back on a read of that register that directly follows it
   assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && pready && paddr[2] == REG_SOURCE_OPACITY)
         ##1 (psel && !pwrite && paddr[2] == REG_SOURCE_OPACITY && !$past(reset))
         |-> prdata == {24'b0, $past(pwdata[7:0])})
      else $error("source opacity read-back mismatch");

endmodule

bind multiply_blend_pixel_unit mbp_checker u_mbp_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data),
   .psel      (psel),
   .penable   (penable),
   .pwrite    (pwrite),
   .paddr     (paddr),
   .pwdata    (pwdata),
   .prdata    (prdata),
   .pready    (pready)
);

`default_nettype wire
